// File: design/lhrt_pkg.sv
// Shared types and constants for the layered hit region table.
// Used by every module of the block but lhrt_region_ram; depends on nothing.
`default_nettype none

package lhrt_pkg;

   // Table sizes.
   localparam int MAX_REGIONS = 64;
   localparam int MAX_LEVELS  = 16;

   // Derived widths: region address, region count (0..MAX_REGIONS), level index.
   localparam int REG_AW = $clog2(MAX_REGIONS);
   localparam int CNT_W  = $clog2(MAX_REGIONS + 1);
   localparam int LVL_W  = $clog2(MAX_LEVELS);

   // Field widths.
   localparam int POS_W  = 15;
   localparam int EDGE_W = POS_W + 1;
   localparam int CODE_W = 16;

   // Command codes.
   typedef enum logic [3:0] {
      CMD_QUERY        = 4'd0,
      CMD_ADD          = 4'd1,
      CMD_OPEN_HIDING  = 4'd2,
      CMD_OPEN_STACKED = 4'd3,
      CMD_CLOSE        = 4'd4,
      CMD_SHOW_MORE    = 4'd5,
      CMD_SHOW_FEWER   = 4'd6,
      CMD_HIDE_OLD     = 4'd7,
      CMD_CLEAR        = 4'd8
   } cmd_type;

   // Control register indexes.
   typedef enum logic [0:0] {
      CSR_ENTER_CODE    = 1'b0,
      CSR_MODIFIER_MASK = 1'b1
   } csr_idx_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOAD_LO,
      ST_SCAN,
      ST_DONE
   } state_type;

   // One stored region: edges and key.
   typedef struct packed {
      logic [POS_W-1:0]  left;
      logic [POS_W-1:0]  top;
      logic [EDGE_W-1:0] right;
      logic [EDGE_W-1:0] bottom;
      logic [CODE_W-1:0] key;
   } region_type;

   // Update request to the level stack.
   typedef struct packed {
      logic             valid;
      cmd_type          cmd;
      logic [CNT_W-1:0] value;
   } ls_upd_type;

   // One result beat.
   typedef struct packed {
      logic [CODE_W-1:0] code_out;
      logic              hit;
      logic              refused;
   } result_type;

endpackage

`default_nettype wire

// File: design/lhrt_region_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
`default_nettype none

module lhrt_region_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: design/lhrt_level_stack.sv
// Level stack: level start offsets, level count and visible level count.
// Depends on lhrt_pkg for widths, command codes and the update struct.
`default_nettype none

module lhrt_level_stack (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [lhrt_pkg::LVL_W-1:0] rd_lvl,
   output logic      [lhrt_pkg::CNT_W-1:0] rd_data,
   input  wire lhrt_pkg::ls_upd_type      upd,
   output logic      [lhrt_pkg::LVL_W-1:0] level_count,
   output logic      [lhrt_pkg::LVL_W-1:0] visible_levels
);
   import lhrt_pkg::*;

   localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1);
   localparam logic [LVL_W-1:0] LVL_CAP = LVL_W'(MAX_LEVELS - 1);

   logic [CNT_W-1:0] starts_ff [MAX_LEVELS];
   logic [CNT_W-1:0] starts_in [MAX_LEVELS];
   logic [LVL_W-1:0] lc_ff, lc_in;
   logic [LVL_W-1:0] vis_ff, vis_in;
   logic [LVL_W-1:0] lc_up;

   // Single read port, address chosen by the sequencer.
   assign rd_data        = starts_ff[rd_lvl];
   assign level_count    = lc_ff;
   assign visible_levels = vis_ff;
   assign lc_up          = lc_ff + LVL_ONE;

   // Next state of the stack for each command.
   always_comb begin
      starts_in = starts_ff;
      lc_in     = lc_ff;
      vis_in    = vis_ff;
      if (upd.valid) begin
         unique case (upd.cmd)
            CMD_ADD: begin
               starts_in[lc_ff] = upd.value;
            end
            CMD_OPEN_HIDING, CMD_OPEN_STACKED: begin
               if (lc_ff != LVL_CAP) begin
                  lc_in            = lc_up;
                  starts_in[lc_up] = upd.value;
                  if (upd.cmd == CMD_OPEN_HIDING) begin
                     vis_in = LVL_ONE;
                  end else if (vis_ff < lc_up) begin
                     vis_in = vis_ff + LVL_ONE;
                  end
               end
            end
            CMD_CLOSE: begin
               if (lc_ff > LVL_ONE) begin
                  lc_in = lc_ff - LVL_ONE;
                  if (vis_ff > LVL_ONE) begin
                     vis_in = vis_ff - LVL_ONE;
                  end
               end
            end
            CMD_SHOW_MORE: begin
               if (vis_ff > LVL_ONE && vis_ff < lc_ff) begin
                  vis_in = vis_ff + LVL_ONE;
               end
            end
            CMD_SHOW_FEWER: begin
               if (vis_ff > LVL_ONE) begin
                  vis_in = vis_ff - LVL_ONE;
               end
            end
            CMD_HIDE_OLD: begin
               vis_in = LVL_ONE;
            end
            CMD_CLEAR: begin
               lc_in              = LVL_ONE;
               vis_in             = LVL_ONE;
               starts_in[LVL_ONE] = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         lc_ff  <= LVL_ONE;
         vis_ff <= LVL_ONE;
         for (int k = 0; k < MAX_LEVELS; k++) begin
            starts_ff[k] <= '0;
         end
      end else begin
         lc_ff     <= lc_in;
         vis_ff    <= vis_in;
         starts_ff <= starts_in;
      end
   end

   // The visible count stays within one and the level count.
   a_vis_range: assert property (@(posedge clock) disable iff (reset)
      1'b1 |-> (vis_ff != '0 && vis_ff <= lc_ff))
      else $error("visible level count out of range");

   // The level count stays between one and the cap, one short of the start store depth.
   a_lc_range: assert property (@(posedge clock) disable iff (reset)
      1'b1 |-> (lc_ff != '0 && lc_ff <= LVL_CAP))
      else $error("level count out of range");

   // The end of the top level never points past the region table.
   a_top_end: assert property (@(posedge clock) disable iff (reset)
      1'b1 |-> (starts_ff[lc_ff] <= CNT_W'(MAX_REGIONS)))
      else $error("top level end beyond region table");

endmodule

`default_nettype wire

// File: design/lhrt_ctrl.sv
// Sequencer: captures an input beat, edits the table or scans the region RAM.
// Depends on lhrt_pkg; drives lhrt_level_stack and lhrt_region_ram.
`default_nettype none

module lhrt_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [3:0]                  req_cmd,
   input  wire logic [lhrt_pkg::POS_W-1:0]  req_pos_x,
   input  wire logic [lhrt_pkg::POS_W-1:0]  req_pos_y,
   input  wire logic [lhrt_pkg::POS_W-1:0]  req_size_x,
   input  wire logic [lhrt_pkg::POS_W-1:0]  req_size_y,
   input  wire logic [lhrt_pkg::CODE_W-1:0] req_code_in,
   input  wire logic [lhrt_pkg::CODE_W-1:0] enter_code,
   input  wire logic [lhrt_pkg::CODE_W-1:0] modifier_mask,
   output logic      [lhrt_pkg::LVL_W-1:0]  ls_rd_lvl,
   input  wire logic [lhrt_pkg::CNT_W-1:0]  ls_rd_data,
   input  wire logic [lhrt_pkg::LVL_W-1:0]  level_count,
   input  wire logic [lhrt_pkg::LVL_W-1:0]  visible_levels,
   output lhrt_pkg::ls_upd_type             ls_upd,
   output logic                             ram_wr_en,
   output logic      [lhrt_pkg::REG_AW-1:0] ram_wr_addr,
   output lhrt_pkg::region_type             ram_wr_data,
   output logic                             ram_rd_en,
   output logic      [lhrt_pkg::REG_AW-1:0] ram_rd_addr,
   input  wire lhrt_pkg::region_type        ram_rd_data,
   output logic                             res_valid,
   output lhrt_pkg::result_type             res,
   input  wire logic                        res_take
);
   import lhrt_pkg::*;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [POS_W-1:0]  px_ff, px_in, py_ff, py_in;
   logic [POS_W-1:0]  sx_ff, sx_in, sy_ff, sy_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [CNT_W-1:0]  hi_ff, hi_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              pend_ff, pend_in;
   result_type        res_ff, res_in;
   logic              encloses;

   // Enclosure test on the entry read in the previous cycle.
   assign encloses = (ram_rd_data.left <= px_ff) && (ram_rd_data.top <= py_ff)
                  && (ram_rd_data.right > {1'b0, px_ff})
                  && (ram_rd_data.bottom > {1'b0, py_ff});

   assign res = res_ff;

   // Next state and outputs.
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      sx_in       = sx_ff;
      sy_in       = sy_ff;
      code_in     = code_ff;
      hi_in       = hi_ff;
      idx_in      = idx_ff;
      pend_in     = pend_ff;
      res_in      = res_ff;
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      ls_rd_lvl   = level_count;
      ls_upd      = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = ls_rd_data[REG_AW-1:0];
      ram_wr_data.left   = px_ff;
      ram_wr_data.top    = py_ff;
      ram_wr_data.right  = {1'b0, px_ff} + {1'b0, sx_ff};
      ram_wr_data.bottom = {1'b0, py_ff} + {1'b0, sy_ff};
      ram_wr_data.key    = code_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff[REG_AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid) begin
               cmd_in   = cmd_type'(req_cmd);
               px_in    = req_pos_x;
               py_in    = req_pos_y;
               sx_in    = req_size_x;
               sy_in    = req_size_y;
               code_in  = req_code_in;
               state_in = ST_EXEC;
            end
         end

         // Read the end of the top level and act on the command.
         ST_EXEC: begin
            res_in   = '0;
            state_in = ST_DONE;
            unique case (cmd_ff)
               CMD_QUERY: begin
                  if ((code_ff & ~modifier_mask) != enter_code) begin
                     res_in.code_out = code_ff;
                  end else begin
                     res_in.code_out = enter_code;
                     hi_in           = ls_rd_data;
                     state_in        = ST_LOAD_LO;
                  end
               end
               CMD_ADD: begin
                  if (ls_rd_data >= CNT_W'(MAX_REGIONS)) begin
                     res_in.refused = 1'b1;
                  end else begin
                     ram_wr_en    = 1'b1;
                     ls_upd.valid = 1'b1;
                     ls_upd.cmd   = CMD_ADD;
                     ls_upd.value = ls_rd_data + CNT_W'(1);
                  end
               end
               CMD_OPEN_HIDING, CMD_OPEN_STACKED, CMD_CLOSE, CMD_SHOW_MORE,
               CMD_SHOW_FEWER, CMD_HIDE_OLD, CMD_CLEAR: begin
                  ls_upd.valid = 1'b1;
                  ls_upd.cmd   = cmd_ff;
                  ls_upd.value = ls_rd_data;
               end
               default: begin
               end
            endcase
         end

         // Read the start of the lowest visible level.
         ST_LOAD_LO: begin
            ls_rd_lvl = level_count - visible_levels;
            idx_in    = ls_rd_data;
            pend_in   = 1'b0;
            state_in  = ST_SCAN;
         end

         // One RAM read issued and one entry tested per cycle.
         ST_SCAN: begin
            if (pend_ff && encloses) begin
               res_in.code_out = ram_rd_data.key;
               res_in.hit      = 1'b1;
               pend_in         = 1'b0;
               state_in        = ST_DONE;
            end else if (idx_ff < hi_ff) begin
               ram_rd_en = 1'b1;
               idx_in    = idx_ff + CNT_W'(1);
               pend_in   = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      code_ff <= code_in;
      hi_ff   <= hi_in;
      idx_ff  <= idx_in;
      res_ff  <= res_in;
   end

   // The region RAM is read only while scanning.
   a_rd_in_scan: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |-> state_ff == ST_SCAN)
      else $error("region read outside a scan");

   // The scan pointer never passes the end of the top level.
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> idx_ff <= hi_ff)
      else $error("scan pointer beyond top level");

   // A refusal belongs to an add and a hit to a query, never both.
   a_res_kind: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> (!res_ff.refused || cmd_ff == CMD_ADD)
                           && (!res_ff.hit || cmd_ff == CMD_QUERY))
      else $error("result flag does not match command");

endmodule

`default_nettype wire

// File: design/layered_hit_region_table.sv
// Layered hit region table: top level with control registers and result stage.
// Depends on lhrt_pkg, lhrt_ctrl, lhrt_level_stack and lhrt_region_ram.
//
// Usage:
//   req_* carries one command beat (query, add, level edits, clear). Each beat
//   gives exactly one rsp_* beat: the resulting code, a hit flag for queries
//   and a refused flag for an add into a full table.
//   csr_* writes enter_code (index 0) and modifier_mask (index 1); it is ready
//   whenever reset is low and should be used only while no command is in flight.
//   Commands are handled one at a time. A non-scanning command passes through
//   the execute and done states, and the next beat is taken once the result
//   has moved into the output register. A lookup query reads the region RAM
//   one entry per cycle over the visible levels, so the single RAM read port
//   sets the query rate.
//   The result sits in an output register, so a new command is accepted while
//   the previous result waits on rsp_ready; a further result then waits inside
//   until the output register frees.
//   Synchronous reset empties the level stack (one level, one visible, no
//   regions) and clears both control registers. Region RAM is not cleared;
//   only entries written by adds are ever read.
`default_nettype none

module layered_hit_region_table (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [3:0]                  req_cmd,
   input  wire logic [lhrt_pkg::POS_W-1:0]  req_pos_x,
   input  wire logic [lhrt_pkg::POS_W-1:0]  req_pos_y,
   input  wire logic [lhrt_pkg::POS_W-1:0]  req_size_x,
   input  wire logic [lhrt_pkg::POS_W-1:0]  req_size_y,
   input  wire logic [lhrt_pkg::CODE_W-1:0] req_code_in,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic      [lhrt_pkg::CODE_W-1:0] rsp_code_out,
   output logic                             rsp_hit,
   output logic                             rsp_refused,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [0:0]                  csr_index,
   input  wire logic [lhrt_pkg::CODE_W-1:0] csr_wdata
);
   import lhrt_pkg::*;

   logic [CODE_W-1:0] enter_code_ff, mask_ff;
   logic [LVL_W-1:0]  ls_rd_lvl, level_count, visible_levels;
   logic [CNT_W-1:0]  ls_rd_data;
   ls_upd_type        ls_upd;
   logic              ram_wr_en, ram_rd_en;
   logic [REG_AW-1:0] ram_wr_addr, ram_rd_addr;
   region_type        ram_wr_data, ram_rd_data;
   logic              res_valid, res_take;
   result_type        res;
   logic              rsp_valid_ff;
   result_type        rsp_ff;

   // Control registers.
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         enter_code_ff <= '0;
         mask_ff       <= '0;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_ENTER_CODE:    enter_code_ff <= csr_wdata;
            CSR_MODIFIER_MASK: mask_ff       <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   lhrt_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_size_x     (req_size_x),
      .req_size_y     (req_size_y),
      .req_code_in    (req_code_in),
      .enter_code     (enter_code_ff),
      .modifier_mask  (mask_ff),
      .ls_rd_lvl      (ls_rd_lvl),
      .ls_rd_data     (ls_rd_data),
      .level_count    (level_count),
      .visible_levels (visible_levels),
      .ls_upd         (ls_upd),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_en      (ram_rd_en),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data),
      .res_valid      (res_valid),
      .res            (res),
      .res_take       (res_take)
   );

   lhrt_level_stack u_level_stack (
      .clock          (clock),
      .reset          (reset),
      .rd_lvl         (ls_rd_lvl),
      .rd_data        (ls_rd_data),
      .upd            (ls_upd),
      .level_count    (level_count),
      .visible_levels (visible_levels)
   );

   lhrt_region_ram #(
      .WIDTH ($bits(region_type)),
      .DEPTH (MAX_REGIONS)
   ) u_region_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Output register: loads when empty or when its beat leaves this cycle.
   assign res_take = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_take) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_code_out = rsp_ff.code_out;
   assign rsp_hit      = rsp_ff.hit;
   assign rsp_refused  = rsp_ff.refused;

endmodule

`default_nettype wire

// File: verif/hit_table_check_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the layered hit region table: a software copy of the region
// table and level stack that predicts every result beat. Depends on lhrt_pkg.
package hit_table_check_pkg;
   import lhrt_pkg::*;

   class hit_table_scoreboard;
      // Copy of the two control registers.
      bit [CODE_W-1:0] enter_code;
      bit [CODE_W-1:0] modifier_mask;

      // Copy of the region table and the level stack.
      bit [POS_W-1:0]  rect_left   [MAX_REGIONS];
      bit [POS_W-1:0]  rect_top    [MAX_REGIONS];
      bit [EDGE_W-1:0] rect_right  [MAX_REGIONS];
      bit [EDGE_W-1:0] rect_bottom [MAX_REGIONS];
      bit [CODE_W-1:0] rect_key    [MAX_REGIONS];
      bit [CNT_W-1:0]  level_base  [MAX_LEVELS];
      bit [LVL_W-1:0]  level_total;
      bit [LVL_W-1:0]  level_shown;

      // Result beats still to come, oldest first.
      result_type      awaited[$];
      int              fail_count;

      function new();
         level_total = 1;
         level_shown = 1;
         fail_count  = 0;
      endfunction

      function void write_register(csr_idx_type idx, bit [CODE_W-1:0] value);
         case (idx)
            CSR_ENTER_CODE:    enter_code    = value;
            CSR_MODIFIER_MASK: modifier_mask = value;
         endcase
      endfunction

      // First region index of the lowest visible level.
      function int visible_first();
         return level_base[level_total - level_shown];
      endfunction

      // One past the last region of the top level.
      function int visible_end();
         return level_base[level_total];
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction

      // A new level starts empty; the stack stops one short of its depth.
      function void open_level(bit hide_older);
         if (level_total < MAX_LEVELS - 1) begin
            level_total++;
            if (hide_older)
               level_shown = 1;
            else if (level_shown < level_total)
               level_shown++;
            level_base[level_total] = level_base[level_total - 1];
         end
      endfunction

      // Applies one accepted command beat and queues the result it must give.
      function void note_command(bit [3:0] cmd, bit [POS_W-1:0] px, bit [POS_W-1:0] py,
                                 bit [POS_W-1:0] sx, bit [POS_W-1:0] sy,
                                 bit [CODE_W-1:0] code);
         result_type r;
         int         slot;
         r = '0;
         case (cmd)
            CMD_QUERY: begin
               // Only a plain click, modifiers masked, looks up the regions.
               if ((code & ~modifier_mask) != enter_code) begin
                  r.code_out = code;
               end else begin
                  r.code_out = enter_code;
                  for (int i = visible_first(); i < visible_end() && i < MAX_REGIONS; i++) begin
                     if (rect_left[i] <= px && rect_top[i] <= py &&
                         rect_right[i] > px && rect_bottom[i] > py) begin
                        r.code_out = rect_key[i];
                        r.hit      = 1'b1;
                        break;
                     end
                  end
               end
            end
            CMD_ADD: begin
               slot = level_base[level_total];
               if (slot >= MAX_REGIONS) begin
                  r.refused = 1'b1;
               end else begin
                  rect_left[slot]   = px;
                  rect_top[slot]    = py;
                  rect_right[slot]  = {1'b0, px} + {1'b0, sx};
                  rect_bottom[slot] = {1'b0, py} + {1'b0, sy};
                  rect_key[slot]    = code;
                  level_base[level_total] = CNT_W'(slot + 1);
               end
            end
            CMD_OPEN_HIDING:  open_level(1'b1);
            CMD_OPEN_STACKED: open_level(1'b0);
            CMD_CLOSE: begin
               if (level_total > 1) begin
                  level_total--;
                  if (level_shown > 1)
                     level_shown--;
               end
            end
            CMD_SHOW_MORE: begin
               if (level_shown > 1 && level_shown < level_total)
                  level_shown++;
            end
            CMD_SHOW_FEWER: begin
               if (level_shown > 1)
                  level_shown--;
            end
            CMD_HIDE_OLD: level_shown = 1;
            CMD_CLEAR: begin
               level_total   = 1;
               level_shown   = 1;
               level_base[1] = '0;
            end
            default: ;
         endcase
         awaited.push_back(r);
      endfunction

      // Compares one result beat with the oldest expectation.
      function void check_result(logic [CODE_W-1:0] code_out, logic hit, logic refused);
         result_type want;
         if (awaited.size() == 0) begin
            $display("%0t: result beat with nothing expected: code_out %h hit %b refused %b",
                     $time, code_out, hit, refused);
            fail_count++;
            return;
         end
         want = awaited.pop_front();
         if (code_out !== want.code_out) begin
            $display("%0t: code_out expected %h, actual %h", $time, want.code_out, code_out);
            fail_count++;
         end
         if (hit !== want.hit) begin
            $display("%0t: hit expected %b, actual %b", $time, want.hit, hit);
            fail_count++;
         end
         if (refused !== want.refused) begin
            $display("%0t: refused expected %b, actual %b", $time, want.refused, refused);
            fail_count++;
         end
      endfunction
   endclass

endpackage

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Top of the testbench for the layered hit region table: clock, reset, command
// and result drivers, and the stimulus. Depends on lhrt_pkg and hit_table_check_pkg.
module testbench;
   import lhrt_pkg::*;
   import hit_table_check_pkg::*;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [3:0]          req_cmd;
   logic [POS_W-1:0]    req_pos_x;
   logic [POS_W-1:0]    req_pos_y;
   logic [POS_W-1:0]    req_size_x;
   logic [POS_W-1:0]    req_size_y;
   logic [CODE_W-1:0]   req_code_in;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [CODE_W-1:0]   rsp_code_out;
   logic                rsp_hit;
   logic                rsp_refused;
   logic                csr_valid;
   logic                csr_ready;
   logic [0:0]          csr_index;
   logic [CODE_W-1:0]   csr_wdata;

   // While set, neither side inserts idle cycles.
   bit                  quiet;
   hit_table_scoreboard sb;

   layered_hit_region_table uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_pos_x    (req_pos_x),
      .req_pos_y    (req_pos_y),
      .req_size_x   (req_size_x),
      .req_size_y   (req_size_y),
      .req_code_in  (req_code_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_code_out (rsp_code_out),
      .rsp_hit      (rsp_hit),
      .rsp_refused  (rsp_refused),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin : watchdog
      #3_000_000;
      $display("testbench NOT OK");
      $finish;
   end

   // Result side: stall a random number of cycles, then take one beat.
   initial begin : result_sink
      int stall;
      rsp_ready = 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         sb.check_result(rsp_code_out, rsp_hit, rsp_refused);
      end
   end

   // Drives one command beat, records it once accepted, then idles for a random gap unless quiet.
   task automatic send_command(input bit [3:0] cmd, input bit [POS_W-1:0] px,
                               input bit [POS_W-1:0] py, input bit [POS_W-1:0] sx,
                               input bit [POS_W-1:0] sy, input bit [CODE_W-1:0] code);
      int gap;
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_pos_x   <= px;
      req_pos_y   <= py;
      req_size_x  <= sx;
      req_size_y  <= sy;
      req_code_in <= code;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_command(cmd, px, py, sx, sy, code);
      gap = quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Holds off new commands until every result is back, then lets the block settle.
   task automatic wait_for_results(input int settle);
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (sb.outstanding() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (settle) @(posedge clock);
   endtask

   // Writes both control registers back to back on the register channel.
   task automatic configure(input bit [CODE_W-1:0] enter, input bit [CODE_W-1:0] mask);
      csr_valid <= 1'b1;
      csr_index <= CSR_ENTER_CODE;
      csr_wdata <= enter;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_register(CSR_ENTER_CODE, enter);
      csr_index <= CSR_MODIFIER_MASK;
      csr_wdata <= mask;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_register(CSR_MODIFIER_MASK, mask);
      csr_valid <= 1'b0;
      repeat (2) @(posedge clock);
   endtask

   // Weighted pick of the next command; queries and adds dominate.
   function automatic bit [3:0] choose_command();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return CMD_QUERY;
      if (roll < 68) return CMD_ADD;
      if (roll < 73) return CMD_OPEN_STACKED;
      if (roll < 77) return CMD_OPEN_HIDING;
      if (roll < 82) return CMD_CLOSE;
      if (roll < 86) return CMD_SHOW_MORE;
      if (roll < 90) return CMD_SHOW_FEWER;
      if (roll < 93) return CMD_HIDE_OLD;
      if (roll < 94) return CMD_CLEAR;
      return 4'($urandom_range(9, 15));
   endfunction

   // Region edges cluster near the origin so regions overlap often.
   function automatic bit [POS_W-1:0] pick_coord();
      if ($urandom_range(0, 3) == 0)
         return POS_W'($urandom);
      return POS_W'($urandom_range(0, 4095));
   endfunction

   function automatic bit [POS_W-1:0] pick_extent();
      case ($urandom_range(0, 9))
         0:       return '0;
         1, 2:    return POS_W'($urandom);
         default: return POS_W'($urandom_range(1, 2000));
      endcase
   endfunction

   // A query coordinate on either edge of a region, just past it, or inside it.
   function automatic bit [POS_W-1:0] aim_coord(input int lo_edge, input int hi_edge);
      int c;
      case ($urandom_range(0, 3))
         0:       c = lo_edge;
         1:       c = hi_edge - 1;
         2:       c = hi_edge;
         default: c = (hi_edge > lo_edge) ? lo_edge + $urandom_range(0, hi_edge - lo_edge - 1)
                                          : lo_edge;
      endcase
      if (c < 0 || c > 2**POS_W - 1)
         c = lo_edge;
      return c[POS_W-1:0];
   endfunction

   // Builds and sends one random beat of the given command.
   task automatic random_item(input bit [3:0] cmd);
      bit [POS_W-1:0]  px;
      bit [POS_W-1:0]  py;
      bit [POS_W-1:0]  sx;
      bit [POS_W-1:0]  sy;
      bit [CODE_W-1:0] code;
      int              first;
      int              stop;
      int              pick;
      px   = pick_coord();
      py   = pick_coord();
      sx   = pick_extent();
      sy   = pick_extent();
      code = CODE_W'($urandom);
      if (cmd == CMD_QUERY) begin
         // Mostly plain clicks with random modifier bits, the rest pass through.
         if ($urandom_range(0, 3) != 0)
            code = (sb.enter_code & ~sb.modifier_mask) | (code & sb.modifier_mask);
         first = sb.visible_first();
         stop  = sb.visible_end();
         if (stop > first && $urandom_range(0, 3) != 0) begin
            pick = $urandom_range(first, stop - 1);
            px   = aim_coord(sb.rect_left[pick], sb.rect_right[pick]);
            py   = aim_coord(sb.rect_top[pick], sb.rect_bottom[pick]);
         end
      end
      send_command(cmd, px, py, sx, sy, code);
   endtask

   // Edges of the coordinate space, zero-size regions, masked clicks and
   // every level operation including the ones that must be ignored.
   task automatic directed_sequence();
      bit [CODE_W-1:0] click;
      click = sb.enter_code;
      send_command(CMD_ADD, '0, '0, 15'h7FFF, 15'h7FFF, 16'h5A5A);
      send_command(CMD_QUERY, 15'h7FFE, 15'h7FFE, '0, '0, click);
      send_command(CMD_QUERY, 15'h7FFF, 15'h7FFF, '0, '0, click);
      send_command(CMD_ADD, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 16'hFFFF);
      send_command(CMD_QUERY, 15'h7FFF, 15'h7FFF, '0, '0, click);
      send_command(CMD_QUERY, '0, '0, '0, '0, click ^ 16'h0002);
      send_command(CMD_QUERY, '0, '0, '0, '0, click | 16'hF000);
      send_command(CMD_OPEN_HIDING, '0, '0, '0, '0, '0);
      send_command(CMD_ADD, 15'd100, 15'd100, '0, 15'd5, 16'h1111);
      send_command(CMD_QUERY, 15'd100, 15'd100, '0, '0, click);
      send_command(CMD_SHOW_MORE, '0, '0, '0, '0, '0);
      send_command(CMD_QUERY, '0, '0, '0, '0, click);
      send_command(CMD_OPEN_STACKED, '0, '0, '0, '0, '0);
      send_command(CMD_SHOW_MORE, '0, '0, '0, '0, '0);
      send_command(CMD_QUERY, '0, '0, '0, '0, click);
      send_command(CMD_SHOW_FEWER, '0, '0, '0, '0, '0);
      send_command(CMD_QUERY, '0, '0, '0, '0, click);
      send_command(CMD_CLOSE, '0, '0, '0, '0, '0);
      send_command(CMD_HIDE_OLD, '0, '0, '0, '0, '0);
      send_command(CMD_CLOSE, '0, '0, '0, '0, '0);
      send_command(CMD_CLOSE, '0, '0, '0, '0, '0);
      send_command(4'd9, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 16'hFFFF);
      send_command(4'd15, '0, '0, '0, '0, '0);
      send_command(CMD_CLEAR, '0, '0, '0, '0, '0);
      send_command(CMD_QUERY, '0, '0, '0, '0, click);
   endtask

   initial begin : stimulus
      bit [CODE_W-1:0] enter_set [7] = '{16'h0001, 16'h0000, 16'hFFFF, 16'h0000,
                                         16'h8000, 16'h00F0, 16'h0000};
      bit [CODE_W-1:0] mask_set  [7] = '{16'hF000, 16'h0000, 16'h0000, 16'hFFFF,
                                         16'h7FFF, 16'h00FF, 16'h0000};
      bit [CODE_W-1:0] enter;
      bit [CODE_W-1:0] mask;
      sb          = new();
      quiet       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_cmd     = '0;
      req_pos_x   = '0;
      req_pos_y   = '0;
      req_size_x  = '0;
      req_size_y  = '0;
      req_code_in = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Each phase runs under its own register setting; the last is random.
      for (int p = 0; p < 7; p++) begin
         enter = enter_set[p];
         mask  = mask_set[p];
         if (p == 6) begin
            enter = CODE_W'($urandom);
            mask  = CODE_W'($urandom) & ~enter;
         end
         configure(enter, mask);
         if (p == 0)
            directed_sequence();
         // Overfill the table, or push the level stack into its cap.
         if (p % 2 == 0)
            repeat (MAX_REGIONS + 4) random_item(CMD_ADD);
         else
            repeat (MAX_LEVELS) random_item(CMD_OPEN_STACKED);
         for (int n = 0; n < 200; n++) begin
            if (n % 50 == 0)
               quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) == 0)
               wait_for_results(0);
            random_item(choose_command());
         end
         quiet = 1'b0;
         wait_for_results(80);
      end

      if (sb.outstanding() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, sb.outstanding());
         sb.fail_count++;
      end
      if (sb.fail_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
